FILE: hdl/lfsa_pkg.sv
package lfsa_pkg;

    localparam int SLOTS      = 64;
    localparam int REQUESTERS = 1024;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int ID_W       = $clog2(REQUESTERS);
    localparam int USE_W      = 16;
    localparam logic [USE_W-1:0] USE_MAX = {USE_W{1'b1}};

    // Event kinds carried on the mode field.
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_DEPART = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_FREE   = 2'd1,
        STATUS_NO_HOLDER = 2'd2
    } t_status;

    // Controller to datapath.
    typedef struct packed {
        logic clr;      // write one invalid holder entry during the clearing pass
        logic accept;   // latch the input word and read the holder table
        logic look;     // pick the slot and read its use counter
        logic update;   // write back state and load the output word
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last;  // clearing pass is at the last holder entry
        logic out_full;  // output word is held and not taken this cycle
    } t_sts;

endpackage

FILE: hdl/lfsa_ctrl.sv
module lfsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lfsa_pkg::t_sts i_sts,
    output lfsa_pkg::t_cmd o_cmd
);
    import lfsa_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!i_sts.out_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_cmd.clr    = (r_state == ST_CLEAR);
    assign o_cmd.accept = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.look   = (r_state == ST_LOOK);
    assign o_cmd.update = (r_state == ST_UPDATE) && !i_sts.out_full;

endmodule

FILE: hdl/lfsa_dp.sv
module lfsa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfsa_pkg::t_cmd                i_cmd,
    output lfsa_pkg::t_sts                o_sts,
    input  logic                          i_mode,
    input  logic [9:0]                    i_requester_id,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lfsa_pkg::SLOT_W-1:0]   o_slot,
    output logic [lfsa_pkg::USE_W-1:0]    o_slot_uses,
    output logic [1:0]                    o_status
);
    import lfsa_pkg::*;

    typedef enum logic [2:0] {
        K_REPEAT,
        K_NEW,
        K_DEPART,
        K_NO_FREE,
        K_NO_HOLDER
    } t_kind;

    // Holder table: valid bit and slot number per requester.
    logic [SLOT_W:0]    hold_mem [REQUESTERS];
    // Use counters, with a valid bit per slot standing for the reset value zero.
    logic [USE_W-1:0]   use_mem  [SLOTS];
    logic [SLOTS-1:0]   r_use_vld;
    logic [SLOTS-1:0]   r_busy;

    logic               r_mode;
    logic [ID_W-1:0]    r_id;
    logic [ID_W-1:0]    r_clr_idx;
    logic [SLOT_W:0]    r_hold_rd;
    logic [USE_W-1:0]   r_use_rd;
    logic               r_use_rd_vld;
    t_kind              r_kind;
    logic [SLOT_W-1:0]  r_slot;

    logic [SLOT_W-1:0]  free_idx;
    logic               free_any;
    t_kind              look_kind;
    logic [SLOT_W-1:0]  look_slot;
    logic [USE_W-1:0]   cur_uses;
    logic [USE_W-1:0]   inc_uses;

    // Lowest free slot from the busy map.
    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end
    assign free_any = ~&r_busy;

    always_comb begin
        look_slot = r_hold_rd[SLOT_W-1:0];
        if (r_hold_rd[SLOT_W]) begin
            look_kind = r_mode ? K_DEPART : K_REPEAT;
        end else if (r_mode) begin
            look_kind = K_NO_HOLDER;
        end else if (free_any) begin
            look_kind = K_NEW;
            look_slot = free_idx;
        end else begin
            look_kind = K_NO_FREE;
        end
    end

    assign cur_uses = r_use_rd_vld ? r_use_rd : '0;
    assign inc_uses = (cur_uses == USE_MAX) ? cur_uses : cur_uses + 1'b1;

    // Holder table port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            hold_mem[r_clr_idx] <= '0;
        end else if (i_cmd.update && (r_kind == K_NEW)) begin
            hold_mem[r_id] <= {1'b1, r_slot};
        end else if (i_cmd.update && (r_kind == K_DEPART)) begin
            hold_mem[r_id] <= '0;
        end
        if (i_cmd.accept) begin
            r_hold_rd <= hold_mem[i_requester_id[ID_W-1:0]];
        end
    end

    // Use counter port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && (r_kind == K_NEW)) begin
            use_mem[r_slot] <= inc_uses;
        end
        if (i_cmd.look) begin
            r_use_rd <= use_mem[look_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_id   <= i_requester_id[ID_W-1:0];
        end
        if (i_cmd.look) begin
            r_kind <= look_kind;
            r_slot <= look_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx    <= '0;
            r_busy       <= '0;
            r_use_vld    <= '0;
            r_use_rd_vld <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.look) begin
                r_use_rd_vld <= r_use_vld[look_slot];
            end
            if (i_cmd.update && (r_kind == K_NEW)) begin
                r_busy[r_slot]    <= 1'b1;
                r_use_vld[r_slot] <= 1'b1;
            end else if (i_cmd.update && (r_kind == K_DEPART)) begin
                r_busy[r_slot] <= 1'b0;
            end
            if (i_cmd.update) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            case (r_kind)
                K_NEW: begin
                    o_slot      <= r_slot;
                    o_slot_uses <= inc_uses;
                    o_status    <= STATUS_OK;
                end
                K_REPEAT, K_DEPART: begin
                    o_slot      <= r_slot;
                    o_slot_uses <= cur_uses;
                    o_status    <= STATUS_OK;
                end
                K_NO_FREE: begin
                    o_slot      <= '0;
                    o_slot_uses <= '0;
                    o_status    <= STATUS_NO_FREE;
                end
                default: begin
                    o_slot      <= '0;
                    o_slot_uses <= '0;
                    o_status    <= STATUS_NO_HOLDER;
                end
            endcase
        end
    end

    assign o_sts.clr_last = &r_clr_idx;
    assign o_sts.out_full = o_out_valid && !i_out_ready;

endmodule

FILE: hdl/lowest_free_slot_allocator.sv
// An accepted word goes through the look step, then the update step, which loads the
// output word and waits while an earlier output word is not taken. A new word is only
// accepted after the last is written back, as the holder table read, use counter read
// and write-back each go through a synchronous memory port in turn. Reset (synchronous,
// active low) frees all slots and zeroes the use counts at once, then clears all 1024
// holder table entries in a pass before the first word is accepted.
module lowest_free_slot_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [9:0]                    i_requester_id,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lfsa_pkg::SLOT_W-1:0]   o_slot,
    output logic [lfsa_pkg::USE_W-1:0]    o_slot_uses,
    output logic [1:0]                    o_status
);
    import lfsa_pkg::*;

    // The controller sequences each word through three steps: accept and read the
    // holder entry, choose the slot and read its use counter, then write back the
    // busy map, holder entry and counter while loading the output register. The
    // write-back waits while a previous output word has not been taken.
    t_cmd cmd;
    t_sts sts;

    lfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the busy map, the holder table and the use counters. An
    // arrival by a requester that already holds a slot reports that slot again
    // without changing anything; requester ids wrap to the table depth.
    lfsa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_mode),
        .i_requester_id (i_requester_id),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_slot         (o_slot),
        .o_slot_uses    (o_slot_uses),
        .o_status       (o_status)
    );

endmodule

FILE: tb/slot_grant_checker.sv
module slot_grant_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_mode,
    input  logic [9:0]                  i_requester_id,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [lfsa_pkg::SLOT_W-1:0] i_slot,
    input  logic [lfsa_pkg::USE_W-1:0]  i_slot_uses,
    input  logic [1:0]                  i_status,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_no_free,
    output int                          o_no_holder
);
    import lfsa_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [USE_W-1:0]  uses;
        t_status           status;
    } t_grant;

    // Shadow copy of the allocator state.
    logic [SLOTS-1:0]  slot_busy;
    logic              held_valid [REQUESTERS];
    logic [SLOT_W-1:0] held_slot  [REQUESTERS];
    logic [USE_W-1:0]  use_count  [SLOTS];

    t_grant expected_grants [$];
    t_grant oldest_grant;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s is %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    // Applies one event to the shadow state and returns the word it should produce.
    function automatic t_grant grant_for_event(input logic mode, input logic [ID_W-1:0] id);
        t_grant            g;
        logic              found;
        logic [SLOT_W-1:0] pick;
        g.slot   = '0;
        g.uses   = '0;
        g.status = STATUS_OK;
        found    = 1'b0;
        pick     = '0;
        if (mode == MODE_ARRIVE) begin
            if (held_valid[id]) begin
                // A requester asking again keeps its slot and nothing changes.
                g.slot = held_slot[id];
                g.uses = use_count[held_slot[id]];
            end else begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!found && !slot_busy[s]) begin
                        found = 1'b1;
                        pick  = SLOT_W'(s);
                    end
                end
                if (!found) begin
                    g.status = STATUS_NO_FREE;
                end else begin
                    slot_busy[pick] = 1'b1;
                    held_valid[id]  = 1'b1;
                    held_slot[id]   = pick;
                    if (use_count[pick] != USE_MAX) begin
                        use_count[pick] = use_count[pick] + 1'b1;
                    end
                    g.slot = pick;
                    g.uses = use_count[pick];
                end
            end
        end else begin
            if (!held_valid[id]) begin
                g.status = STATUS_NO_HOLDER;
            end else begin
                pick            = held_slot[id];
                slot_busy[pick] = 1'b0;
                held_valid[id]  = 1'b0;
                g.slot          = pick;
                g.uses          = use_count[pick];
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_busy = '0;
            for (int r = 0; r < REQUESTERS; r++) begin
                held_valid[r] = 1'b0;
                held_slot[r]  = '0;
            end
            for (int s = 0; s < SLOTS; s++) begin
                use_count[s] = '0;
            end
            expected_grants.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_no_free    = 0;
            o_no_holder  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch("result word with nothing expected, status",
                                    int'(i_status), 0);
                end else begin
                    oldest_grant = expected_grants.pop_front();
                    if (i_slot !== oldest_grant.slot) begin
                        report_mismatch("slot", int'(i_slot), int'(oldest_grant.slot));
                    end
                    if (i_slot_uses !== oldest_grant.uses) begin
                        report_mismatch("slot_uses", int'(i_slot_uses),
                                        int'(oldest_grant.uses));
                    end
                    if (i_status !== oldest_grant.status) begin
                        report_mismatch("status", int'(i_status), int'(oldest_grant.status));
                    end
                    o_checked++;
                    if (oldest_grant.status == STATUS_NO_FREE) begin
                        o_no_free++;
                    end
                    if (oldest_grant.status == STATUS_NO_HOLDER) begin
                        o_no_holder++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_grants.push_back(grant_for_event(i_mode, i_requester_id[ID_W-1:0]));
            end
        end
        o_pending = expected_grants.size();
    end

endmodule

FILE: tb/tb_lowest_free_slot_allocator.sv
module tb_lowest_free_slot_allocator;
    import lfsa_pkg::*;

    // Once reset and the holder-table clearing pass are over, no stretch without a
    // handshake should come near this many cycles, even with both sides idling most
    // of the time.
    localparam int WATCHDOG_LIMIT = 5000;
    // Cycles allowed after the last result word.
    localparam int SETTLE_CYCLES  = 12;
    localparam int POOL_SIZE      = 96;
    localparam int PHASE_WORDS    = 303;
    localparam int REUSE_PAIRS    = 48;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              mode;
    logic [9:0]        requester_id;
    logic              out_valid;
    logic              out_ready;
    logic [SLOT_W-1:0] slot;
    logic [USE_W-1:0]  slot_uses;
    logic [1:0]        status;

    int fail_count;
    int pending;
    int checked;
    int no_free;
    int no_holder;

    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles;
    int words_sent;

    logic [9:0] requester_pool [POOL_SIZE];

    lowest_free_slot_allocator u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_mode         (mode),
        .i_requester_id (requester_id),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_slot         (slot),
        .o_slot_uses    (slot_uses),
        .o_status       (status)
    );

    slot_grant_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_mode         (mode),
        .i_requester_id (requester_id),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_slot         (slot),
        .i_slot_uses    (slot_uses),
        .i_status       (status),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_no_free      (no_free),
        .o_no_holder    (no_holder)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver decides at every falling edge whether it takes a word at the next
    // rising edge. The stall rate is set per phase by the stimulus process.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Watchdog: any stretch in which neither channel moves a word is counted, and a
    // stretch that reaches the limit means the block has hung.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_lowest_free_slot_allocator failed");
            $finish;
        end
    end

    // Offers one word. Gaps are inserted before the word according to the sender idle
    // rate; once valid is raised it stays high with the payload held until the block
    // takes the word. Valid is never lowered between two back-to-back words, so there
    // is only one assignment to it in any falling edge.
    task automatic send_word(input logic word_mode, input logic [9:0] word_id);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        mode         = word_mode;
        requester_id = word_id;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    // Holds the sender off until every word sent so far has produced its result.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    // One random phase. Arrivals and departures alternate in dominance every 60 words,
    // so the slots fill up completely (driving the no-free-slot path) and then drain
    // again. Most ids come from a small pool so that repeated arrivals and departures
    // of real holders are common; the rest span the whole id range.
    task automatic random_phase(input int idle_pct, input int stall_pct);
        int         arrive_pct;
        logic       word_mode;
        logic [9:0] word_id;
        wait_for_results();
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int k = 0; k < PHASE_WORDS; k++) begin
            arrive_pct = ((k / 60) % 2 == 0) ? 80 : 25;
            word_mode  = ($urandom_range(0, 99) < arrive_pct) ? MODE_ARRIVE : MODE_DEPART;
            if ($urandom_range(0, 99) < 85) begin
                word_id = requester_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                word_id = 10'($urandom_range(0, 1023));
            end
            send_word(word_mode, word_id);
        end
    endtask

    initial begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        mode               = MODE_ARRIVE;
        requester_id       = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        words_sent         = 0;

        requester_pool[0] = 10'd0;
        requester_pool[1] = 10'd1023;
        for (int p = 2; p < POOL_SIZE; p++) begin
            requester_pool[p] = 10'($urandom_range(0, 1023));
        end

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed words: a departure before anything is held, the first grant, a
        // repeated arrival, the extreme ids, and a freed slot being handed out again.
        send_word(MODE_DEPART, 10'd0);
        send_word(MODE_ARRIVE, 10'd0);
        send_word(MODE_ARRIVE, 10'd0);
        send_word(MODE_ARRIVE, 10'd1023);
        send_word(MODE_ARRIVE, 10'h2AA);
        send_word(MODE_DEPART, 10'd0);
        send_word(MODE_ARRIVE, 10'h155);
        send_word(MODE_DEPART, 10'd1023);
        send_word(MODE_DEPART, 10'd1023);
        send_word(MODE_ARRIVE, 10'd1023);

        // Fill every slot from fresh ids; the last arrivals find no free slot.
        for (int k = 0; k < SLOTS; k++) begin
            send_word(MODE_ARRIVE, 10'(200 + k));
        end
        for (int k = 0; k < SLOTS; k++) begin
            send_word(MODE_DEPART, 10'(200 + k));
        end
        send_word(MODE_DEPART, 10'h2AA);
        send_word(MODE_DEPART, 10'h155);
        send_word(MODE_DEPART, 10'd1023);

        // With every slot free again, arrive-depart pairs land on slot 0 over and over,
        // so its use counter climbs with each grant. The ids are spread over the table.
        wait_for_results();
        for (int k = 0; k < REUSE_PAIRS; k++) begin
            send_word(MODE_ARRIVE, 10'(k * 21));
            send_word(MODE_DEPART, 10'(k * 21));
        end

        random_phase(0, 0);
        random_phase(66, 0);
        random_phase(0, 66);
        random_phase(27, 27);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d words and %0d checked results, %0d of them with no free slot",
                 words_sent, checked, no_free);
        $display("and %0d departures without a slot, under four sender and receiver idle mixes.",
                 no_holder);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_lowest_free_slot_allocator passed");
        end else begin
            $display("tb_lowest_free_slot_allocator failed");
        end
        $finish;
    end

endmodule
